// ----- hdl/npr_pkg.sv -----
// ----------------------------------------------------------------------------
// npr_pkg
// Types and constants shared by the nearest prototype search block: beat
// layouts, operation codes and the tag that follows a cell through the scan.
// ----------------------------------------------------------------------------
package npr_pkg;

  localparam int OP_W        = 2;
  localparam int IDX_W       = 8;
  localparam int FEAT_W      = 16;
  localparam int IN_FEATURES = 4;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = 36;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         cell_index;
    logic                     cell_used;
    logic signed [FEAT_W-1:0] feature_0;
    logic signed [FEAT_W-1:0] feature_1;
    logic signed [FEAT_W-1:0] feature_2;
    logic signed [FEAT_W-1:0] feature_3;
    logic [DIST_W-1:0]        radius_sq;
  } npr_in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  best_cell;
    logic [DIST_W-1:0] best_dist_sq;
  } npr_out_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic used;
  } scan_tag_t;

endpackage

// ----- hdl/npr_store.sv -----
// ----------------------------------------------------------------------------
// npr_store
// Prototype memory and in-use mark memory with one write port each and a
// shared registered read port; the scan tag is carried alongside the read.
// ----------------------------------------------------------------------------
module npr_store
  import npr_pkg::*;
#(
  parameter int CELL_COUNT    = 256,
  parameter int FEATURE_COUNT = 4,
  localparam int AW = $clog2(CELL_COUNT),
  localparam int PW = FEATURE_COUNT * FEAT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          proto_we,
  input  logic          mark_we,
  input  logic [AW-1:0] wr_addr,
  input  logic [PW-1:0] wr_proto,
  input  logic          wr_mark,
  input  logic [AW-1:0] rd_addr,
  input  scan_tag_t     rd_tag,
  output logic [PW-1:0] rd_proto_r,
  output logic [AW-1:0] rd_idx_r,
  output scan_tag_t     rd_tag_out
);

  logic [PW-1:0] proto_mem [CELL_COUNT];
  logic          mark_mem  [CELL_COUNT];
  logic          rd_mark_r;
  scan_tag_t     rd_tag_r;

  always_ff @(posedge clk) begin
    if (proto_we) begin
      proto_mem[wr_addr] <= wr_proto;
    end
    if (mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    rd_proto_r <= proto_mem[rd_addr];
    rd_mark_r  <= mark_mem[rd_addr];
    rd_idx_r   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= rd_tag;
    end
  end

  always_comb begin
    rd_tag_out      = rd_tag_r;
    rd_tag_out.used = rd_mark_r;
  end

endmodule

// ----- hdl/npr_lane.sv -----
// ----------------------------------------------------------------------------
// npr_lane
// One feature lane: exact difference of a prototype feature and the context
// feature, its magnitude squared into a register.
// ----------------------------------------------------------------------------
module npr_lane
  import npr_pkg::*;
(
  input  logic                     clk,
  input  logic signed [FEAT_W-1:0] proto_feat,
  input  logic signed [FEAT_W-1:0] ctx_feat,
  output logic [SQ_W-1:0]          sq_r
);

  logic signed [FEAT_W:0] diff;
  logic [FEAT_W:0]        neg;
  logic [FEAT_W-1:0]      mag;

  always_comb begin
    diff = {proto_feat[FEAT_W-1], proto_feat} - {ctx_feat[FEAT_W-1], ctx_feat};
    neg  = -diff;
    mag  = diff[FEAT_W] ? neg[FEAT_W-1:0] : diff[FEAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    sq_r <= mag * mag;
  end

endmodule

// ----- hdl/npr_merge.sv -----
// ----------------------------------------------------------------------------
// npr_merge
// Sums the lane squares into a distance, then keeps the best in-radius cell
// of the scan. Later cells win on equal distance.
// ----------------------------------------------------------------------------
module npr_merge
  import npr_pkg::*;
#(
  parameter int CELL_COUNT    = 256,
  parameter int FEATURE_COUNT = 4,
  localparam int AW = $clog2(CELL_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [FEATURE_COUNT*SQ_W-1:0] sq_in,
  input  scan_tag_t                     tag_in,
  input  logic [AW-1:0]                 idx_in,
  input  logic [DIST_W-1:0]             radius,
  output logic                          hit_r,
  output logic [AW-1:0]                 best_idx_r,
  output logic [DIST_W-1:0]             best_dist_r,
  output logic                          done_r
);

  logic [DIST_W-1:0] sum_nxt;
  logic [DIST_W-1:0] sum_a_r;
  scan_tag_t         tag_a_r;
  logic [AW-1:0]     idx_a_r;
  logic              qual;
  logic              hit_nxt;
  logic [AW-1:0]     best_idx_nxt;
  logic [DIST_W-1:0] best_dist_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < FEATURE_COUNT; k++) begin
      sum_nxt = sum_nxt + DIST_W'(sq_in[k*SQ_W +: SQ_W]);
    end
  end

  always_ff @(posedge clk) begin
    sum_a_r <= sum_nxt;
    idx_a_r <= idx_in;
  end

  always_comb begin
    qual          = tag_a_r.used && (sum_a_r <= radius);
    hit_nxt       = hit_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    if (tag_a_r.vld) begin
      if (tag_a_r.first) begin
        hit_nxt       = qual;
        best_idx_nxt  = idx_a_r;
        best_dist_nxt = sum_a_r;
      end else if (qual && (!hit_r || sum_a_r <= best_dist_r)) begin
        hit_nxt       = 1'b1;
        best_idx_nxt  = idx_a_r;
        best_dist_nxt = sum_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      hit_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      tag_a_r <= tag_in;
      hit_r   <= hit_nxt;
      done_r  <= tag_a_r.vld && tag_a_r.last;
    end
  end

endmodule

// ----- hdl/nearest_prototype_within_radius_core.sv -----
// ----------------------------------------------------------------------------
// nearest_prototype_within_radius_core
// Squared-Euclidean nearest prototype search over a stored table of cells,
// one feature lane per dimension and a merging stage that tracks the winner.
// ----------------------------------------------------------------------------
//   channel  handshake             beat
//   in       in_valid / in_ready   npr_in_t  (clear, load or query)
//   out      out_valid / out_ready npr_out_t (one per query)
//
// A load or an unused code leaves the block idle. A query reads one cell a
// cycle from the prototype memory through the store read, lane square, merge
// sum and best-cell registers into the output register. A clear, and reset,
// zero every mark cell while in_ready is low. A held result does not stop the
// next load or clear; a finished query waits for the output register to free.
// ----------------------------------------------------------------------------
module nearest_prototype_within_radius_core
  import npr_pkg::*;
#(
  parameter int CELL_COUNT    = 256,
  parameter int FEATURE_COUNT = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  npr_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output npr_out_t out_item
);

  localparam int AW = $clog2(CELL_COUNT);
  localparam int PW = FEATURE_COUNT * FEAT_W;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(CELL_COUNT - 1);
  localparam logic [16:0]   CELL_LIMIT = 17'(CELL_COUNT);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic              issuing_r, issuing_nxt;
  logic [PW-1:0]     ctx_r;
  logic [DIST_W-1:0] radius_r;
  logic              out_valid_r;
  npr_out_t          out_item_r;

  logic                     in_acc;
  logic                     load_ok;
  logic signed [FEAT_W-1:0] in_feat [IN_FEATURES];
  logic [PW-1:0]            feat_vec;
  logic                     proto_we, mark_we;
  logic [AW-1:0]            wr_addr;
  logic                     wr_mark;
  scan_tag_t                rd_tag;
  scan_tag_t                tag_s;
  logic [PW-1:0]            proto_s;
  logic [AW-1:0]            idx_s;
  scan_tag_t                tag_l_r;
  logic [AW-1:0]            idx_l_r;
  logic [FEATURE_COUNT*SQ_W-1:0] sq_vec;
  logic                     hit;
  logic [AW-1:0]            best_idx;
  logic [DIST_W-1:0]        best_dist;
  logic                     scan_done;
  logic                     out_load;
  logic [AW+IDX_W-1:0]      best_idx_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = 17'(in_item.cell_index) < CELL_LIMIT;

  assign in_feat[0] = in_item.feature_0;
  assign in_feat[1] = in_item.feature_1;
  assign in_feat[2] = in_item.feature_2;
  assign in_feat[3] = in_item.feature_3;

  always_comb begin
    for (int k = 0; k < FEATURE_COUNT; k++) begin
      feat_vec[k*FEAT_W +: FEAT_W] = (k < IN_FEATURES) ? in_feat[k % IN_FEATURES] : '0;
    end
  end

  always_comb begin
    proto_we = in_acc && (in_item.operation == OP_LOAD) && load_ok;
    mark_we  = proto_we || (state_r == ST_CLEAR);
    wr_addr  = (state_r == ST_CLEAR) ? addr_r : AW'(in_item.cell_index);
    wr_mark  = (state_r == ST_CLEAR) ? 1'b0 : in_item.cell_used;
    rd_tag.vld   = (state_r == ST_SCAN) && issuing_r;
    rd_tag.first = (addr_r == '0);
    rd_tag.last  = (addr_r == LAST_ADDR);
    rd_tag.used  = 1'b0;
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    issuing_nxt = issuing_r;
    case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.operation == OP_CLEAR) begin
            addr_nxt  = '0;
            state_nxt = ST_CLEAR;
          end else if (in_item.operation == OP_QUERY) begin
            addr_nxt    = '0;
            issuing_nxt = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issuing_r) begin
          if (addr_r == LAST_ADDR) begin
            issuing_nxt = 1'b0;
            addr_nxt    = '0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      issuing_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tag_l_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      issuing_r <= issuing_nxt;
      tag_l_r   <= tag_s;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign best_idx_ext = {{IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    idx_l_r <= idx_s;
    if (in_acc && in_item.operation == OP_QUERY) begin
      ctx_r    <= feat_vec;
      radius_r <= in_item.radius_sq;
    end
    if (out_load) begin
      out_item_r.found        <= hit;
      out_item_r.best_cell    <= hit ? best_idx_ext[IDX_W-1:0] : '0;
      out_item_r.best_dist_sq <= hit ? best_dist : '0;
    end
  end

  npr_store #(
    .CELL_COUNT   (CELL_COUNT),
    .FEATURE_COUNT(FEATURE_COUNT)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .proto_we  (proto_we),
    .mark_we   (mark_we),
    .wr_addr   (wr_addr),
    .wr_proto  (feat_vec),
    .wr_mark   (wr_mark),
    .rd_addr   (addr_r),
    .rd_tag    (rd_tag),
    .rd_proto_r(proto_s),
    .rd_idx_r  (idx_s),
    .rd_tag_out(tag_s)
  );

  for (genvar g = 0; g < FEATURE_COUNT; g++) begin : g_lane
    npr_lane u_lane (
      .clk       (clk),
      .proto_feat(proto_s[g*FEAT_W +: FEAT_W]),
      .ctx_feat  (ctx_r[g*FEAT_W +: FEAT_W]),
      .sq_r      (sq_vec[g*SQ_W +: SQ_W])
    );
  end

  npr_merge #(
    .CELL_COUNT   (CELL_COUNT),
    .FEATURE_COUNT(FEATURE_COUNT)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .sq_in      (sq_vec),
    .tag_in     (tag_l_r),
    .idx_in     (idx_l_r),
    .radius     (radius_r),
    .hit_r      (hit),
    .best_idx_r (best_idx),
    .best_dist_r(best_dist),
    .done_r     (scan_done)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_done_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == ST_SCAN)
    else $error("scan finished outside a query");

  a_read_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tag_s.vld |-> $past(state_r) == ST_SCAN)
    else $error("cell read outside a query");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.found |->
      out_item_r.best_cell == '0 && out_item_r.best_dist_sq == '0)
    else $error("miss carries a non-zero cell or distance");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat raised without a finished query");
`endif

endmodule

// ----- tb/sv/prototype_match_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prototype_match_checker
// Watches both channels of the nearest prototype search block. It keeps its
// own copy of the marks and prototypes, works out the winner of every query
// when the query beat is taken, and compares each result beat with the oldest
// outstanding answer.
// ----------------------------------------------------------------------------
module prototype_match_checker
  import npr_pkg::*;
#(
  parameter int CELLS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  npr_in_t  in_item,
  input  logic     out_valid,
  input  logic     out_ready,
  input  npr_out_t out_item,
  output int       error_count,
  output int       answers_due,
  output int       hit_count,
  output int       miss_count
);

  logic                     in_use [CELLS];
  logic signed [FEAT_W-1:0] proto  [CELLS][IN_FEATURES];
  npr_out_t                 predicted_answers [$];
  int                       errors;
  int                       hits;
  int                       misses;

  initial begin
    errors = 0;
    hits   = 0;
    misses = 0;
    for (int c = 0; c < CELLS; c++) begin
      for (int k = 0; k < IN_FEATURES; k++) begin
        proto[c][k] = '0;
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic npr_out_t nearest_within_radius(input npr_in_t q);
    logic signed [FEAT_W-1:0] ctx [IN_FEATURES];
    logic signed [FEAT_W:0]   diff;
    logic [FEAT_W:0]          mag;
    logic [DIST_W-1:0]        cell_dist;
    npr_out_t                 res;
    ctx[0] = q.feature_0;
    ctx[1] = q.feature_1;
    ctx[2] = q.feature_2;
    ctx[3] = q.feature_3;
    res = '0;
    for (int c = 0; c < CELLS; c++) begin
      if (in_use[c]) begin
        cell_dist = '0;
        for (int k = 0; k < IN_FEATURES; k++) begin
          diff = proto[c][k] - ctx[k];
          mag  = diff[FEAT_W] ? -diff : diff;
          cell_dist = cell_dist + mag * mag;
        end
        // The scan runs upwards, so an equal distance hands the win to the higher cell.
        if (cell_dist <= q.radius_sq && (!res.found || cell_dist <= res.best_dist_sq)) begin
          res.found        = 1'b1;
          res.best_cell    = IDX_W'(c);
          res.best_dist_sq = cell_dist;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    npr_out_t want;
    if (!rst_n) begin
      for (int c = 0; c < CELLS; c++) begin
        in_use[c] = 1'b0;
      end
      predicted_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_answers.size() == 0) begin
          flag_mismatch($sformatf("result beat with no query outstanding (found %0b, cell %0d)",
                                  out_item.found, out_item.best_cell));
        end else begin
          want = predicted_answers.pop_front();
          if (out_item.found !== want.found) begin
            flag_mismatch($sformatf("found is %0b, should be %0b", out_item.found, want.found));
          end
          if (out_item.best_cell !== want.best_cell) begin
            flag_mismatch($sformatf("best_cell is %0d, should be %0d",
                                    out_item.best_cell, want.best_cell));
          end
          if (out_item.best_dist_sq !== want.best_dist_sq) begin
            flag_mismatch($sformatf("best_dist_sq is %0d, should be %0d",
                                    out_item.best_dist_sq, want.best_dist_sq));
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_item.operation)
          OP_CLEAR: begin
            for (int c = 0; c < CELLS; c++) begin
              in_use[c] = 1'b0;
            end
          end
          OP_LOAD: begin
            if (in_item.cell_index < CELLS) begin
              proto[in_item.cell_index][0] = in_item.feature_0;
              proto[in_item.cell_index][1] = in_item.feature_1;
              proto[in_item.cell_index][2] = in_item.feature_2;
              proto[in_item.cell_index][3] = in_item.feature_3;
              in_use[in_item.cell_index]   = in_item.cell_used;
            end
          end
          OP_QUERY: begin
            want = nearest_within_radius(in_item);
            predicted_answers.push_back(want);
            if (want.found) begin
              hits++;
            end else begin
              misses++;
            end
          end
          default: begin
          end
        endcase
      end
    end
    error_count <= errors;
    answers_due <= predicted_answers.size();
    hit_count   <= hits;
    miss_count  <= misses;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the nearest prototype search block: a directed opening on the
// extreme features, ties, dropped marks and clears, then random loads and
// queries aimed around stored prototypes, with bursts of idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import npr_pkg::*;

  localparam int                CELLS        = 256;
  localparam int                RANDOM_BEATS = 480;
  localparam int                TAIL_BEATS   = 60;
  localparam logic [OP_W-1:0]   OP_SPARE     = 2'd3;
  localparam logic [DIST_W-1:0] FAR_SQ       = 36'd17179344900;
  localparam logic [4*FEAT_W-1:0] TOP_VEC    = {4{16'h7FFF}};
  localparam logic [4*FEAT_W-1:0] BOTTOM_VEC = {4{16'h8000}};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  npr_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  npr_out_t out_item;

  int error_count;
  int answers_due;
  int hit_count;
  int miss_count;

  bit                  steady;
  int                  n_load;
  int                  n_query;
  int                  n_clear;
  int                  n_spare;
  logic [4*FEAT_W-1:0] last_feats [CELLS];
  bit                  ever_loaded [CELLS];
  logic [IDX_W-1:0]    loaded_cells [$];
  logic [4*FEAT_W-1:0] hub [4];

  nearest_prototype_within_radius_core #(
    .CELL_COUNT    (CELLS),
    .FEATURE_COUNT (IN_FEATURES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  prototype_match_checker #(
    .CELLS (CELLS)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .error_count (error_count),
    .answers_due (answers_due),
    .hit_count   (hit_count),
    .miss_count  (miss_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic npr_in_t beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                   input logic used, input logic [4*FEAT_W-1:0] feats,
                                   input logic [DIST_W-1:0] r);
    npr_in_t b;
    b.operation  = op;
    b.cell_index = idx;
    b.cell_used  = used;
    b.feature_0  = feats[4*FEAT_W-1 -: FEAT_W];
    b.feature_1  = feats[3*FEAT_W-1 -: FEAT_W];
    b.feature_2  = feats[2*FEAT_W-1 -: FEAT_W];
    b.feature_3  = feats[FEAT_W-1 -: FEAT_W];
    b.radius_sq  = r;
    return b;
  endfunction

  function automatic logic [4*FEAT_W-1:0] near(input logic [4*FEAT_W-1:0] v, input int span);
    logic [4*FEAT_W-1:0] r;
    for (int k = 0; k < IN_FEATURES; k++) begin
      r[k*FEAT_W +: FEAT_W] = v[k*FEAT_W +: FEAT_W] + FEAT_W'($urandom_range(0, 2 * span))
                              - FEAT_W'(span);
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] pick_radius();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DIST_W'($urandom_range(0, 64));
      2:       return DIST_W'($urandom_range(0, 4000));
      3:       return DIST_W'({$urandom, $urandom});
      4:       return FAR_SQ;
      default: return '1;
    endcase
  endfunction

  task automatic send_beat(input npr_in_t b);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_item  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (b.operation)
      OP_CLEAR: n_clear++;
      OP_LOAD: begin
        n_load++;
        last_feats[b.cell_index] = {b.feature_0, b.feature_1, b.feature_2, b.feature_3};
        if (!ever_loaded[b.cell_index]) begin
          ever_loaded[b.cell_index] = 1'b1;
          loaded_cells.push_back(b.cell_index);
        end
      end
      OP_QUERY: n_query++;
      default:  n_spare++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    int                  n;
    int                  pick;
    logic [IDX_W-1:0]    idx;
    logic [4*FEAT_W-1:0] fv;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    steady   = 1'b0;
    n_load   = 0;
    n_query  = 0;
    n_clear  = 0;
    n_spare  = 0;
    for (int c = 0; c < CELLS; c++) begin
      ever_loaded[c] = 1'b0;
      last_feats[c]  = '0;
    end
    for (int h = 0; h < 4; h++) begin
      hub[h] = {$urandom, $urandom};
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(beat(OP_QUERY, 8'd0, 1'b0, TOP_VEC, '1));
    send_beat(beat(OP_LOAD, 8'd0, 1'b1, BOTTOM_VEC, '0));
    send_beat(beat(OP_LOAD, 8'd255, 1'b1, TOP_VEC, '1));
    send_beat(beat(OP_QUERY, 8'd255, 1'b1, TOP_VEC, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, BOTTOM_VEC, '1));
    send_beat(beat(OP_LOAD, 8'd255, 1'b0, TOP_VEC, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, TOP_VEC, FAR_SQ - 1));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, TOP_VEC, FAR_SQ));
    send_beat(beat(OP_LOAD, 8'd10, 1'b1, {16'd1, 16'd2, 16'd3, 16'd4}, '0));
    send_beat(beat(OP_LOAD, 8'd20, 1'b1, {16'd1, 16'd2, 16'd3, 16'd4}, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, {16'd1, 16'd2, 16'd3, 16'd5}, 36'd1));
    send_beat(beat(OP_LOAD, 8'd20, 1'b0, {16'd100, 16'd2, 16'd3, 16'd4}, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, {16'd1, 16'd2, 16'd3, 16'd5}, 36'd1));
    send_beat(beat(OP_SPARE, 8'd20, 1'b1, {$urandom, $urandom}, '1));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, {16'd1, 16'd2, 16'd3, 16'd5}, 36'd1));
    send_beat(beat(OP_CLEAR, 8'hA5, 1'b1, {$urandom, $urandom}, '1));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, BOTTOM_VEC, '1));
    send_beat(beat(OP_LOAD, 8'd10, 1'b1, {16'd1, 16'd2, 16'd3, 16'd4}, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, {16'd1, 16'd2, 16'd3, 16'd4}, '0));
    send_beat(beat(OP_LOAD, 8'd128, 1'b1, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, '0));
    send_beat(beat(OP_QUERY, 8'd0, 1'b0, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, '1));

    n = 0;
    while (n < RANDOM_BEATS) begin
      steady = (n >= RANDOM_BEATS - TAIL_BEATS) || (n >= 180 && n < 230);
      if (n == 260) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_beat(beat(OP_CLEAR, IDX_W'($urandom), 1'($urandom), {$urandom, $urandom},
                       DIST_W'({$urandom, $urandom})));
        n++;
      end else if (pick < 5) begin
        send_beat(beat(OP_SPARE, IDX_W'($urandom), 1'($urandom), {$urandom, $urandom},
                       DIST_W'({$urandom, $urandom})));
      end else if (pick < 45) begin
        idx = ($urandom_range(0, 1) == 1) ? IDX_W'($urandom_range(0, 15))
                                          : IDX_W'($urandom_range(0, CELLS - 1));
        case ($urandom_range(0, 2))
          0: fv = {$urandom, $urandom};
          1: fv = near(hub[$urandom_range(0, 3)], 12);
          default: begin
            if (loaded_cells.size() > 0) begin
              fv = last_feats[loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]];
            end else begin
              fv = {$urandom, $urandom};
            end
          end
        endcase
        send_beat(beat(OP_LOAD, idx, $urandom_range(0, 4) != 0, fv,
                       DIST_W'({$urandom, $urandom})));
        n++;
      end else begin
        if (loaded_cells.size() > 0 && $urandom_range(0, 9) < 7) begin
          fv = last_feats[loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]];
          fv = near(fv, ($urandom_range(0, 1) == 1) ? 0 : 20);
        end else begin
          fv = {$urandom, $urandom};
        end
        send_beat(beat(OP_QUERY, IDX_W'($urandom), 1'($urandom), fv, pick_radius()));
        n++;
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d loads, %0d queries (%0d within radius, %0d misses),",
             n_load, n_query, hit_count, miss_count);
    $display("%0d clears and %0d beats with the spare operation code.", n_clear, n_spare);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
